@@ rtl/core/c2p_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the chunky-to-planar converter.
// No dependencies; imported by every module in rtl/core.
package c2p_pkg;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned WORDS    = 8;
	localparam int unsigned OFFSET_W = 20;
	localparam int unsigned GROUP_W  = 7;

	typedef logic [WORD_W-1:0]   word_t;
	typedef word_t [WORDS-1:0]   group_t;
	typedef logic [OFFSET_W-1:0] offset_t;

	// One level of the merge network, named by its shift distance
	typedef enum logic [2:0] {
		LVL_16,
		LVL_8,
		LVL_4,
		LVL_2,
		LVL_1
	} merge_level_t;

	// Configuration register indexes
	localparam logic [1:0] CFG_LINE_WIDTH = 2'd0;
	localparam logic [1:0] CFG_X_OFFSET   = 2'd1;
	localparam logic [1:0] CFG_Y_OFFSET   = 2'd2;

	localparam logic [11:0] LINE_WIDTH_RST = 12'd160;
	localparam logic [9:0]  X_OFFSET_RST   = 10'd80;
	localparam logic [9:0]  Y_OFFSET_RST   = 10'd56;

	typedef struct packed {
		logic [11:0] line_width;
		logic [9:0]  x_offset;
		logic [9:0]  y_offset;
	} cfg_t;

endpackage

@@ rtl/core/c2p_merge_lane.sv @@
`timescale 1ns / 1ps
// One XOR-swap merge of two words under the shift and mask of a network level.
// Depends on c2p_pkg.
module c2p_merge_lane import c2p_pkg::*; (
	input  word_t        a,
	input  word_t        b,
	input  merge_level_t level,
	output word_t        a_out,
	output word_t        b_out
);

	word_t t;

	always_comb begin
		unique case (level)
			LVL_16: begin
				t     = ((b >> 16) ^ a) & 32'h0000ffff;
				b_out = b ^ (t << 16);
			end
			LVL_8: begin
				t     = ((b >> 8) ^ a) & 32'h00ff00ff;
				b_out = b ^ (t << 8);
			end
			LVL_4: begin
				t     = ((b >> 4) ^ a) & 32'h0f0f0f0f;
				b_out = b ^ (t << 4);
			end
			LVL_2: begin
				t     = ((b >> 2) ^ a) & 32'h33333333;
				b_out = b ^ (t << 2);
			end
			LVL_1: begin
				t     = ((b >> 1) ^ a) & 32'h55555555;
				b_out = b ^ (t << 1);
			end
			default: begin
				t     = '0;
				b_out = b;
			end
		endcase
		a_out = a ^ t;
	end

endmodule

@@ rtl/core/c2p_merge_level.sv @@
`timescale 1ns / 1ps
// One level of the merge network: four lanes on disjoint word pairs.
// Depends on c2p_pkg and c2p_merge_lane.
module c2p_merge_level import c2p_pkg::*; (
	input  group_t       words_in,
	input  merge_level_t level,
	output group_t       words_out
);

	// Pairing: distance 4 for shifts 16 and 2, distance 2 for 8 and 1, neighbors for 4
	logic [2:0] idx_a [4];
	logic [2:0] idx_b [4];
	word_t      lane_a [4];
	word_t      lane_b [4];
	word_t      res_a [4];
	word_t      res_b [4];

	always_comb begin
		unique case (level)
			LVL_16, LVL_2: begin
				idx_a = '{3'd0, 3'd1, 3'd2, 3'd3};
				idx_b = '{3'd4, 3'd5, 3'd6, 3'd7};
			end
			LVL_8, LVL_1: begin
				idx_a = '{3'd0, 3'd1, 3'd4, 3'd5};
				idx_b = '{3'd2, 3'd3, 3'd6, 3'd7};
			end
			LVL_4: begin
				idx_a = '{3'd0, 3'd2, 3'd4, 3'd6};
				idx_b = '{3'd1, 3'd3, 3'd5, 3'd7};
			end
			default: begin
				idx_a = '{3'd0, 3'd1, 3'd2, 3'd3};
				idx_b = '{3'd4, 3'd5, 3'd6, 3'd7};
			end
		endcase
	end

	for (genvar i = 0; i < 4; i++) begin : g_lane
		assign lane_a[i] = words_in[idx_a[i]];
		assign lane_b[i] = words_in[idx_b[i]];

		c2p_merge_lane u_lane (
			.a     (lane_a[i]),
			.b     (lane_b[i]),
			.level (level),
			.a_out (res_a[i]),
			.b_out (res_b[i])
		);
	end

	always_comb begin
		words_out = words_in;
		for (int i = 0; i < 4; i++) begin
			words_out[idx_a[i]] = res_a[i];
			words_out[idx_b[i]] = res_b[i];
		end
	end

endmodule

@@ rtl/core/c2p_offset_gen.sv @@
`timescale 1ns / 1ps
// Plane byte offset tracking: start offset from the registers, per-group step
// and row skip. Depends on c2p_pkg.
module c2p_offset_gen import c2p_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    step,
	input  logic    frame_end,
	output offset_t offset
);

	logic [21:0]        prod_yw_q;
	logic [19:0]        prod_yx_q;
	offset_t            start_q;
	offset_t            word_pos_q;
	logic [GROUP_W-1:0] group_q;
	logic               started_q;

	logic [22:0]        start_sum;
	offset_t            cur_pos;
	offset_t            pos_inc;
	offset_t            pos_next;
	offset_t            skip;
	logic [GROUP_W-1:0] cur_grp;
	logic [GROUP_W-1:0] grp_inc;
	logic [GROUP_W-1:0] grp_next;
	logic [GROUP_W-1:0] row_groups;

	// Start offset: products are registered first, then summed, shifted and registered again
	assign start_sum = 23'(prod_yw_q) + {2'b00, prod_yx_q, 1'b0} + 23'(cfg.x_offset);

	always_ff @(posedge clk) begin
		prod_yw_q <= 22'(cfg.y_offset) * 22'(cfg.line_width);
		prod_yx_q <= 20'(cfg.y_offset) * 20'(cfg.x_offset);
		start_q   <= start_sum[22:3];
	end

	assign row_groups = cfg.line_width[11:5];
	assign skip       = {12'b0, cfg.x_offset[9:4], 2'b00};
	assign cur_pos    = started_q ? word_pos_q : start_q;
	assign cur_grp    = started_q ? group_q : '0;
	assign pos_inc    = cur_pos + OFFSET_W'(4);
	assign grp_inc    = cur_grp + GROUP_W'(1);
	assign offset     = cur_pos;

	always_comb begin
		priority if (row_groups == '0) begin
			grp_next = '0;
			pos_next = pos_inc;
		end else if (grp_inc >= row_groups) begin
			grp_next = '0;
			pos_next = pos_inc + skip;
		end else begin
			grp_next = grp_inc;
			pos_next = pos_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_pos_q <= '0;
			group_q    <= '0;
			started_q  <= 1'b0;
		end else if (step) begin
			word_pos_q <= pos_next;
			group_q    <= frame_end ? '0 : grp_next;
			started_q  <= !frame_end;
		end
	end

endmodule

@@ rtl/core/chunky_to_planar_converter.sv @@
`timescale 1ns / 1ps
// Chunky-to-planar converter, top level. Depends on c2p_pkg, c2p_merge_level
// and c2p_offset_gen.
//
// Each input transaction carries 32 chunky 8-bit pixels as eight big-endian
// words and yields one output transaction of eight bitplane words plus the
// byte offset of those words within every plane. The block takes one group
// per clock unless the output stalls or the input is held off: the merge
// network is spread across two pipeline registers, so an accepted group
// passes through the first register into the second, which drives the output.
// While a finished group waits on the output, the input takes at most one
// more group and then holds until the output drains. The offset runs from the
// start offset computed from the three registers, advances by four bytes per
// group and adds the row skip after each line; frame_end restarts it for the
// next frame. After reset, and after every register write, the input holds
// off while the start offset multipliers settle. Register writes are taken in
// any cycle.
module chunky_to_planar_converter import c2p_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] chunk_word0,
	input  logic [31:0] chunk_word1,
	input  logic [31:0] chunk_word2,
	input  logic [31:0] chunk_word3,
	input  logic [31:0] chunk_word4,
	input  logic [31:0] chunk_word5,
	input  logic [31:0] chunk_word6,
	input  logic [31:0] chunk_word7,
	input  logic        frame_end,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] plane0,
	output logic [31:0] plane1,
	output logic [31:0] plane2,
	output logic [31:0] plane3,
	output logic [31:0] plane4,
	output logic [31:0] plane5,
	output logic [31:0] plane6,
	output logic [31:0] plane7,
	output logic [19:0] plane_byte_offset
);

	cfg_t       cfg_q;
	logic [1:0] settle_q;
	logic       cfg_we;

	group_t  in_words;
	group_t  lvl16_out;
	group_t  lvl8_out;
	group_t  lvl4_out;
	group_t  lvl2_out;
	group_t  lvl1_out;
	offset_t cur_offset;

	logic    in_fire;
	logic    adv_s1;
	logic    adv_s2;

	logic    valid_s1;
	group_t  words_s1;
	offset_t offset_s1;
	logic    valid_s2;
	group_t  planes_s2;
	offset_t offset_s2;

	// ---------------------------------------------------------------
	// Configuration registers: always ready, unknown indexes dropped
	// ---------------------------------------------------------------
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_width <= LINE_WIDTH_RST;
			cfg_q.x_offset   <= X_OFFSET_RST;
			cfg_q.y_offset   <= Y_OFFSET_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LINE_WIDTH: cfg_q.line_width <= cfg_data;
				CFG_X_OFFSET:   cfg_q.x_offset   <= cfg_data[9:0];
				CFG_Y_OFFSET:   cfg_q.y_offset   <= cfg_data[9:0];
				default:        ;
			endcase
		end
	end

	// Hold the input off until the start offset pipeline reflects the registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= 2'd2;
		end else if (cfg_we) begin
			settle_q <= 2'd2;
		end else if (settle_q != 2'd0) begin
			settle_q <= settle_q - 2'd1;
		end
	end

	// ---------------------------------------------------------------
	// Handshake: each stage advances when the stage after it is free
	// or is draining in this cycle
	// ---------------------------------------------------------------
	assign adv_s2    = !valid_s2 || out_ready;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign in_ready  = adv_s1 && (settle_q == 2'd0);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = valid_s2;

	// ---------------------------------------------------------------
	// Offset generator: advances once per accepted transaction
	// ---------------------------------------------------------------
	c2p_offset_gen u_offset (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.step      (in_fire),
		.frame_end (frame_end),
		.offset    (cur_offset)
	);

	// ---------------------------------------------------------------
	// Merge network, first half: shift 16 and shift 8 levels
	// ---------------------------------------------------------------
	assign in_words = {chunk_word7, chunk_word6, chunk_word5, chunk_word4,
	                   chunk_word3, chunk_word2, chunk_word1, chunk_word0};

	c2p_merge_level u_lvl16 (
		.words_in  (in_words),
		.level     (LVL_16),
		.words_out (lvl16_out)
	);

	c2p_merge_level u_lvl8 (
		.words_in  (lvl16_out),
		.level     (LVL_8),
		.words_out (lvl8_out)
	);

	// ---------------------------------------------------------------
	// Merge network, second half: shift 4, 2 and 1 levels
	// ---------------------------------------------------------------
	c2p_merge_level u_lvl4 (
		.words_in  (words_s1),
		.level     (LVL_4),
		.words_out (lvl4_out)
	);

	c2p_merge_level u_lvl2 (
		.words_in  (lvl4_out),
		.level     (LVL_2),
		.words_out (lvl2_out)
	);

	c2p_merge_level u_lvl1 (
		.words_in  (lvl2_out),
		.level     (LVL_1),
		.words_out (lvl1_out)
	);

	// ---------------------------------------------------------------
	// Pipeline valid bits
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_fire;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// ---------------------------------------------------------------
	// Pipeline payload; the second stage gathers the lane results into
	// plane order (planes 0..7 come from words 7,5,3,1,6,4,2,0)
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_fire) begin
			words_s1  <= lvl8_out;
			offset_s1 <= cur_offset;
		end
		if (adv_s2 && valid_s1) begin
			planes_s2[0] <= lvl1_out[7];
			planes_s2[1] <= lvl1_out[5];
			planes_s2[2] <= lvl1_out[3];
			planes_s2[3] <= lvl1_out[1];
			planes_s2[4] <= lvl1_out[6];
			planes_s2[5] <= lvl1_out[4];
			planes_s2[6] <= lvl1_out[2];
			planes_s2[7] <= lvl1_out[0];
			offset_s2    <= offset_s1;
		end
	end

	assign plane0            = planes_s2[0];
	assign plane1            = planes_s2[1];
	assign plane2            = planes_s2[2];
	assign plane3            = planes_s2[3];
	assign plane4            = planes_s2[4];
	assign plane5            = planes_s2[5];
	assign plane6            = planes_s2[6];
	assign plane7            = planes_s2[7];
	assign plane_byte_offset = offset_s2;

endmodule
